// ===== src/aacs_pkg.sv =====
package aacs_pkg;

  localparam int ADC_BITS  = 10;
  localparam int NUM_AXES  = 3;
  localparam int AXIS_W    = 2;
  localparam int KIND_W    = 2;
  localparam int CNT_W     = 7;
  localparam int SUM_W     = ADC_BITS + CNT_W;
  localparam int MG_W      = 22;
  localparam int DIV_W     = 2 * ((ADC_BITS + 12) / 2);
  localparam int DEN_W     = ADC_BITS;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int PROD_W    = DIV_W + 1;
  localparam int IDX_W     = $clog2(NUM_AXES);

  localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CALIB   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PRESET  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

  localparam logic [CNT_W-1:0]    SAMPLE_COUNT_RST = 7'd10;
  localparam logic [ADC_BITS-1:0] MIDSCALE = {1'b1, {(ADC_BITS - 1){1'b0}}};
  localparam logic [PROD_W-1:0]   SCALE_GAIN   = PROD_W'(2000);
  localparam logic [PROD_W-1:0]   SCALE_OFFSET = PROD_W'(1000);

  localparam logic [ADC_BITS-1:0] PRESET_LO [NUM_AXES] = '{
    ADC_BITS'(394), ADC_BITS'(393), ADC_BITS'(401)
  };
  localparam logic [ADC_BITS-1:0] PRESET_HI [NUM_AXES] = '{
    ADC_BITS'(593), ADC_BITS'(591), ADC_BITS'(601)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_AVG,
    ST_MUL,
    ST_MAP,
    ST_SCALE,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/aacs_in_if.sv =====
interface aacs_in_if import aacs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [AXIS_W-1:0]   axis;
  logic [ADC_BITS-1:0] sample;

  modport source(output valid, kind, axis, sample, input ready);
  modport sink(input valid, kind, axis, sample, output ready);
endinterface

// ===== src/aacs_out_if.sv =====
interface aacs_out_if import aacs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [AXIS_W-1:0]      out_axis;
  logic                   was_calibrate;
  logic [ADC_BITS-1:0]    average;
  logic signed [MG_W-1:0] milli_g;
  logic                   range_zero;

  modport source(output valid, out_axis, was_calibrate, average, milli_g, range_zero,
                 input ready);
  modport sink(input valid, out_axis, was_calibrate, average, milli_g, range_zero,
               output ready);
endinterface

// ===== src/aacs_cfg_if.sv =====
interface aacs_cfg_if import aacs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] sample_count;

  modport source(output valid, sample_count, input ready);
  modport sink(input valid, sample_count, output ready);
endinterface

// ===== src/accel_axis_average_calibrate_scale_unit.sv =====
// Per-axis accelerometer averaging, calibration and linear scaling.
// in_bus   : one beat per raw sample (kind, axis, sample). kind measure or
//            calibrate adds the sample to that axis's running sum; kind preset
//            loads fixed min/max limits for all axes. Unused kind or axis drops.
// out_bus  : one beat each time an axis collects sample_count samples: the
//            truncated mean, and in measure mode the mean mapped from
//            [min,max] to -1000..1000 milli-g (range_zero when min == max).
// cfg_bus  : writes sample_count (0 acts as 1); always ready, write when idle.
// Timing   : in_bus.ready is high only while the sequencer idles, so a new beat
//            is taken only once the last one is through. A calibrate run makes
//            one pass through the one shared divider and a measure run two (one
//            when min == max); the divider forms 2 quotient bits per cycle.
// Stall    : the result sits in an output register until out_bus.ready; the
//            sequencer holds its last state while that register is full.
// Reset    : rst_n (synchronous) clears sums and counts, sets all limits to
//            midscale and sample_count to 10.
module accel_axis_average_calibrate_scale_unit import aacs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  aacs_in_if.sink    in_bus,
  aacs_out_if.source out_bus,
  aacs_cfg_if.sink   cfg_bus
);

  seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]    sample_count_r;
  logic [SUM_W-1:0]    axis_sum_r   [NUM_AXES];
  logic [CNT_W-1:0]    axis_count_r [NUM_AXES];
  logic [ADC_BITS-1:0] axis_min_r   [NUM_AXES];
  logic [ADC_BITS-1:0] axis_max_r   [NUM_AXES];

  logic [KIND_W-1:0]   kind_r;
  logic [AXIS_W-1:0]   axis_r;
  logic [ADC_BITS-1:0] sample_r;
  logic [ADC_BITS-1:0] avg_r;
  logic [PROD_W-1:0]   prod_r;
  logic [DEN_W-1:0]    span_r;
  logic [MG_W-1:0]     mg_r;
  logic                flat_r;

  logic                   out_valid_r;
  logic [AXIS_W-1:0]      out_axis_r;
  logic                   out_calib_r;
  logic [ADC_BITS-1:0]    out_avg_r;
  logic [MG_W-1:0]        out_mg_r;
  logic                   out_flat_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [IDX_W-1:0]    ax;
  logic                axis_ok;
  logic [SUM_W-1:0]    sum_new;
  logic [CNT_W-1:0]    cnt_new;
  logic [CNT_W-1:0]    need;
  logic                complete;
  logic [ADC_BITS-1:0] avg_q;
  logic [ADC_BITS-1:0] lo, hi;
  logic [ADC_BITS-1:0] span;
  logic [PROD_W-1:0]   diff_ext;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   prod_abs;
  logic [PROD_W-1:0]   q_ext;
  logic [PROD_W-1:0]   mg_full;
  logic                out_free;
  logic                in_fire;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  assign ax       = axis_r[IDX_W-1:0];
  assign axis_ok  = (axis_r < AXIS_W'(NUM_AXES));
  assign sum_new  = axis_sum_r[ax] + SUM_W'(sample_r);
  assign cnt_new  = axis_count_r[ax] + CNT_W'(1);
  assign need     = (sample_count_r == '0) ? CNT_W'(1) : sample_count_r;
  assign complete = (cnt_new >= need);
  assign avg_q    = div_rsp.quotient[ADC_BITS-1:0];
  assign lo       = axis_min_r[ax];
  assign hi       = axis_max_r[ax];
  assign span     = hi - lo;
  assign diff_ext = PROD_W'({1'b0, avg_r}) - PROD_W'({1'b0, lo});
  assign prod     = diff_ext * SCALE_GAIN;
  assign prod_abs = prod_r[PROD_W-1] ? (~prod_r + PROD_W'(1)) : prod_r;
  assign q_ext    = PROD_W'(div_rsp.quotient);
  assign mg_full  = (prod_r[PROD_W-1] ? (~q_ext + PROD_W'(1)) : q_ext) - SCALE_OFFSET;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_ACC;
      ST_ACC: begin
        if (kind_r == KIND_PRESET || kind_r == KIND_UNUSED || !axis_ok || !complete) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        if (div_rsp.done) begin
          state_nxt = (kind_r == KIND_CALIB) ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL:   state_nxt = (span == '0) ? ST_OUT : ST_MAP;
      ST_MAP:   state_nxt = ST_SCALE;
      ST_SCALE: if (div_rsp.done) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_req = '0;
    unique case (state_r)
      ST_ACC: begin
        div_req.start    = (kind_r == KIND_MEASURE || kind_r == KIND_CALIB) && axis_ok &&
                           complete;
        div_req.dividend = DIV_W'(sum_new);
        div_req.divisor  = DEN_W'(cnt_new);
      end
      ST_MAP: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_abs[DIV_W-1:0];
        div_req.divisor  = span_r;
      end
      default: div_req = '0;
    endcase
  end

  aacs_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      sample_count_r <= SAMPLE_COUNT_RST;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_sum_r[i]   <= '0;
        axis_count_r[i] <= '0;
        axis_min_r[i]   <= MIDSCALE;
        axis_max_r[i]   <= MIDSCALE;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_bus.valid && cfg_bus.ready) begin
        sample_count_r <= cfg_bus.sample_count;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_ACC: begin
          if (kind_r == KIND_PRESET) begin
            for (int i = 0; i < NUM_AXES; i++) begin
              axis_min_r[i] <= PRESET_LO[i];
              axis_max_r[i] <= PRESET_HI[i];
            end
          end else if (kind_r != KIND_UNUSED && axis_ok) begin
            axis_sum_r[ax]   <= complete ? '0 : sum_new;
            axis_count_r[ax] <= complete ? '0 : cnt_new;
          end
        end
        ST_AVG: begin
          if (div_rsp.done && kind_r == KIND_CALIB) begin
            if (avg_q < lo) axis_min_r[ax] <= avg_q;
            if (avg_q > hi) axis_max_r[ax] <= avg_q;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= in_bus.kind;
      axis_r   <= in_bus.axis;
      sample_r <= in_bus.sample;
    end
    if (state_r == ST_AVG && div_rsp.done) begin
      avg_r  <= avg_q;
      mg_r   <= '0;
      flat_r <= 1'b0;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod;
      span_r <= span;
      flat_r <= (span == '0);
    end
    if (state_r == ST_SCALE && div_rsp.done) begin
      mg_r <= mg_full[MG_W-1:0];
    end
    if (state_r == ST_OUT && out_free) begin
      out_axis_r  <= axis_r;
      out_calib_r <= (kind_r == KIND_CALIB);
      out_avg_r   <= avg_r;
      out_mg_r    <= mg_r;
      out_flat_r  <= flat_r;
    end
  end

  assign in_bus.ready          = (state_r == ST_IDLE);
  assign cfg_bus.ready         = 1'b1;
  assign out_bus.valid         = out_valid_r;
  assign out_bus.out_axis      = out_axis_r;
  assign out_bus.was_calibrate = out_calib_r;
  assign out_bus.average       = out_avg_r;
  assign out_bus.milli_g       = $signed(out_mg_r);
  assign out_bus.range_zero    = out_flat_r;

  a_limits_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    axis_min_r[0] <= axis_max_r[0] && axis_min_r[1] <= axis_max_r[1] &&
    axis_min_r[2] <= axis_max_r[2]) else $error("axis limits out of order");
  a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_ACC) else $error("accepted beat not processed");
  a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    (axis_count_r[0] == '0 |-> axis_sum_r[0] == '0) and
    (axis_count_r[1] == '0 |-> axis_sum_r[1] == '0) and
    (axis_count_r[2] == '0 |-> axis_sum_r[2] == '0)) else $error("sum without samples");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT) else $error("result outside sequence");

endmodule

// ===== src/aacs_div.sv =====
module aacs_div import aacs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    trial;

  // two restoring steps per cycle
  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < 2; i++) begin
      trial   = {rem_nxt, dvd_nxt[DIV_W-1]};
      dvd_nxt = {dvd_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial      = trial - {1'b0, den_r};
        dvd_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == STEP_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r) else $error("done without a run");
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("busy with no steps left");

endmodule
